// ----- rtl/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

  // Queue between the byte front end and the character back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // ASCII anchors for the alphabet ranges and the special characters.
  localparam logic [7:0] CH_UPPER_BASE = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER_BASE = 8'h47;  // 'a' minus 26
  localparam logic [7:0] CH_DIGIT_BASE = 8'hFC;  // '0' minus 52, modulo 256
  localparam logic [7:0] CH_PLUS       = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH      = 8'h2F;  // '/'
  localparam logic [7:0] CH_PAD        = 8'h3D;  // '='

  localparam logic [5:0] SEXTET_MASK   = 6'h3F;
  localparam logic [5:0] SX_LOWER_FIRST = 6'd26;
  localparam logic [5:0] SX_DIGIT_FIRST = 6'd52;
  localparam logic [5:0] SX_PLUS        = 6'd62;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } b64e_in_t;

  // Output transfer payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } b64e_out_t;

  // One output slot: either a sextet to map or a pad character.
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } b64e_slot_t;

  // Work for one input byte: up to four characters, sent from slot 0 upward.
  typedef struct packed {
    b64e_slot_t [3:0] slots;
    logic [1:0]       last_idx;
    logic             last;
  } b64e_entry_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic valid;
  } b64e_qstat_t;

  // Map a sextet to its character of the standard alphabet.
  function automatic logic [7:0] b64e_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < SX_LOWER_FIRST) begin
        return CH_UPPER_BASE + w;
      end else if (v < SX_DIGIT_FIRST) begin
        return CH_LOWER_BASE + w;
      end else if (v < SX_PLUS) begin
        return CH_DIGIT_BASE + w;
      end else if (v == SX_PLUS) begin
        return CH_PLUS;
      end else begin
        return CH_SLASH;
      end
    end
  endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// Front end: accepts bytes, tracks the group position and splits bytes into sextets.
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  b64e_in_t    in_data,
  input  b64e_qstat_t qstat,
  output logic        push,
  output b64e_entry_t push_entry
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] b;

  assign b        = in_data.data_byte;
  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  // Build the character slots for this byte and the next group state.
  always_comb begin
    push_entry = '0;
    push_entry.last = in_data.last_byte;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    case (phase_r)
      PH_SECOND: begin
        push_entry.slots[0].sextet = {left_r[1:0], b[7:4]};
        left_nxt  = b[3:0];
        phase_nxt = PH_THIRD;
        if (in_data.last_byte) begin
          push_entry.slots[1].sextet = {b[3:0], 2'b00};
          push_entry.slots[2].pad    = 1'b1;
          push_entry.last_idx        = 2'd2;
        end
      end
      PH_THIRD: begin
        push_entry.slots[0].sextet = {left_r, b[7:6]};
        push_entry.slots[1].sextet = b[5:0] & SEXTET_MASK;
        push_entry.last_idx        = 2'd1;
        left_nxt  = 4'd0;
        phase_nxt = PH_FIRST;
      end
      default: begin
        push_entry.slots[0].sextet = b[7:2];
        left_nxt  = {2'b00, b[1:0]};
        phase_nxt = PH_SECOND;
        if (in_data.last_byte) begin
          push_entry.slots[1].sextet = {b[1:0], 4'b0000};
          push_entry.slots[2].pad    = 1'b1;
          push_entry.slots[3].pad    = 1'b1;
          push_entry.last_idx        = 2'd3;
        end
      end
    endcase
    // The end of a message returns the group state to its start.
    if (in_data.last_byte) begin
      phase_nxt = PH_FIRST;
      left_nxt  = 4'd0;
    end
  end

  // Group state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      left_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  // A message end leaves the group at its start.
  a_last_resets_group: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_data.last_byte |=> phase_r == PH_FIRST && left_r == 4'd0)
    else $error("group state not cleared after last byte");

  // Leftover bits beyond the low two are empty unless a second byte was taken.
  a_left_width: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_THIRD |-> left_r[3:2] == 2'b00)
    else $error("leftover bits wider than the group position allows");

endmodule

// ----- rtl/b64e_queue.sv -----
// Short queue of per-byte character work between front end and back end.
module b64e_queue import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64e_entry_t push_entry,
  input  logic        pop,
  output b64e_entry_t head,
  output b64e_qstat_t qstat
);

  b64e_entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]          count_r;

  assign head        = mem[rd_ptr_r];
  assign qstat.full  = (count_r == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign qstat.valid = (count_r != '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/b64e_back.sv -----
// Back end: sends queued slots via its output register, one per cycle unless stalled.
module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  b64e_entry_t head,
  input  b64e_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output b64e_out_t   out_data
);

  logic       out_valid_r;
  b64e_out_t  out_data_r, out_data_nxt;
  logic [1:0] idx_r;
  logic       load;
  b64e_slot_t cur;

  assign cur  = head.slots[idx_r];
  assign load = qstat.valid && (!out_valid_r || out_ready);
  assign pop  = load && (idx_r == head.last_idx);

  // Character for the current slot.
  always_comb begin
    out_data_nxt.out_char  = cur.pad ? CH_PAD : b64e_char(cur.sextet);
    out_data_nxt.last_char = head.last && (idx_r == head.last_idx);
  end

  // Slot index within the head entry and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= pop ? 2'd0 : idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The slot index never runs past the head entry's last slot.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.valid |-> idx_r <= head.last_idx)
    else $error("slot index beyond entry");

  // Padding never leads an entry.
  a_pad_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    load && cur.pad |-> idx_r != 2'd0)
    else $error("pad character in first slot");

  // A loaded final character empties its entry and restarts the index.
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_data_nxt.last_char |-> pop ##1 idx_r == 2'd0)
    else $error("final character did not retire its entry");

endmodule

// ----- rtl/base64_stream_encoder_core.sv -----
// Top level of the base64 stream encoder: front end, work queue and character back end.
//
// Usage: raw bytes enter on the in_ channel (valid/ready), each with a flag that marks
// the final byte of a message. Standard base64 characters leave on the out_ channel,
// one per transfer; the final character of a message carries last_char, and the message
// is padded with '=' to a multiple of four characters.
// The first character of a byte is registered in the queue and then in the output
// register. The back end sends one character per cycle while work is queued and
// out_ready is high; a byte yields one character (first or second of a group), two
// (third of a group) or up to four (last byte). The output register's single port
// sets this rate. A two-entry queue sits between the front and back ends, so the
// input keeps taking bytes while earlier characters are still being sent.
// Reset (rst_n low at a clock edge) empties the queue and output register and sets
// the group position to the start of a message.
// When the receiver holds out_ready low, the output register holds its character,
// the queue fills, and in_ready drops once the queue is full.
module base64_stream_encoder_core import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  b64e_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output b64e_out_t out_data
);

  b64e_qstat_t qstat;
  b64e_entry_t push_entry, head;
  logic        push, pop;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb_base64_stream_encoder_core.sv -----
// Self-checking testbench for the base64 stream encoder core.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;
  import b64e_pkg::*;

  // One byte waiting to be sent, with a flag that makes the sender drain first.
  typedef struct {
    b64e_in_t byte_item;
    bit       drain_first;
  } pending_byte_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  b64e_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  b64e_out_t out_data;

  pending_byte_t byte_q[$];
  b64e_out_t     char_q[$];

  int n_bytes_total = 0;
  int n_bytes_sent = 0;
  int chars_owed = 0;
  int cyc = 0;
  int n_fail = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Encoder state as the checker sees it.
  logic [1:0] grp_pos = 2'd0;
  logic [3:0] carry_bits = 4'd0;

  base64_stream_encoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Map a sextet onto the standard alphabet.
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < 8'd26) return 8'd65 + w;
    else if (w < 8'd52) return 8'd71 + w;
    else if (w < 8'd62) return w - 8'd4;
    else if (w == 8'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // Idle length: mostly short, a few long, and none during burst windows.
  function automatic int pick_gap(input int salt);
    int r;
    if (((cyc + salt) / 250) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
    n_fail++;
  endtask

  // Work out the characters one accepted byte produces and queue them.
  task automatic encode_byte(input b64e_in_t item);
    b64e_out_t chars[4];
    int cnt;
    logic [7:0] b;
    b = item.data_byte;
    for (int i = 0; i < 4; i++) begin
      chars[i] = '0;
    end
    case (grp_pos)
      2'd1: begin
        chars[0].out_char = sextet_to_ascii({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        grp_pos = 2'd2;
        cnt = 1;
        if (item.last_byte) begin
          chars[1].out_char = sextet_to_ascii({carry_bits, 2'b00});
          chars[2].out_char = CH_PAD;
          cnt = 3;
        end
      end
      2'd2: begin
        chars[0].out_char = sextet_to_ascii({carry_bits, b[7:6]});
        chars[1].out_char = sextet_to_ascii(b[5:0]);
        carry_bits = 4'd0;
        grp_pos = 2'd0;
        cnt = 2;
      end
      default: begin
        // Start of a group; an impossible position 3 would land here too.
        chars[0].out_char = sextet_to_ascii(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        grp_pos = 2'd1;
        cnt = 1;
        if (item.last_byte) begin
          chars[1].out_char = sextet_to_ascii({b[1:0], 4'b0000});
          chars[2].out_char = CH_PAD;
          chars[3].out_char = CH_PAD;
          cnt = 4;
        end
      end
    endcase
    // The message ends here: mark the final character and restart the group.
    if (item.last_byte) begin
      chars[cnt - 1].last_char = 1'b1;
      grp_pos = 2'd0;
      carry_bits = 4'd0;
    end
    for (int i = 0; i < cnt; i++) begin
      char_q.push_back(chars[i]);
    end
  endtask

  task automatic add_message(input logic [7:0] bytes[$], input bit drain);
    pending_byte_t p;
    for (int i = 0; i < bytes.size(); i++) begin
      p.byte_item.data_byte = bytes[i];
      p.byte_item.last_byte = (i == bytes.size() - 1);
      p.drain_first = drain && (i == 0);
      byte_q.push_back(p);
    end
  endtask

  // Sender: presents queued bytes, holds them until the transfer, then idles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        void'(byte_q.pop_front());
        n_bytes_sent <= n_bytes_sent + 1;
      end
      if (in_valid && !in_ready) begin
        // Keep the byte steady until it is taken.
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (byte_q[0].drain_first && (in_valid || chars_owed != 0)) begin
        // Let every owed character come out before this byte goes in.
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= byte_q[0].byte_item;
        send_gap <= pick_gap(0);
      end
    end
  end

  // Receiver: predicts on each input transfer, checks each output transfer, stalls at random.
  always @(posedge clk) begin : recv_blk
    b64e_out_t want;
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      grp_pos = 2'd0;
      carry_bits = 4'd0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
      end
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          report_mismatch("character with nothing owed", out_data.out_char, 0);
        end else begin
          want = char_q.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch("out_char", out_data.out_char, want.out_char);
          end
          if (out_data.last_char !== want.last_char) begin
            report_mismatch("last_char", out_data.last_char, want.last_char);
          end
        end
      end
      chars_owed <= char_q.size();
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0 && pick_gap(125) != 0) begin
        recv_gap <= pick_gap(125);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main_blk
    logic [7:0] msg[$];
    int len;
    int r;
    int n_random;
    bit first_random;

    // Directed messages: every group position at the end, extreme bytes, '+' and '/'.
    msg = '{8'h00};                      add_message(msg, 1'b0);
    msg = '{8'hFF};                      add_message(msg, 1'b0);
    msg = '{8'h00, 8'hFF};               add_message(msg, 1'b0);
    msg = '{8'hFF, 8'h00, 8'hFF};        add_message(msg, 1'b0);
    msg = '{8'hFF, 8'hFF, 8'hFF};        add_message(msg, 1'b0);
    msg = '{8'hFB, 8'hEF, 8'hBE};        add_message(msg, 1'b0);
    msg = '{8'h00, 8'h00, 8'h00, 8'h80}; add_message(msg, 1'b0);
    msg = '{8'h4D, 8'h61, 8'h6E, 8'h01, 8'hFE}; add_message(msg, 1'b0);

    // Random messages, mostly short, some long, a few sent only after a full drain.
    n_random = 0;
    first_random = 1'b1;
    while (n_random < 128) begin
      r = $urandom_range(0, 99);
      if (r < 15) len = 1;
      else if (r < 75) len = $urandom_range(2, 7);
      else len = $urandom_range(8, 20);
      msg = {};
      for (int i = 0; i < len; i++) begin
        msg.push_back(8'($urandom_range(0, 255)));
      end
      add_message(msg, first_random || ($urandom_range(0, 19) == 0));
      first_random = 1'b0;
      n_random += len;
    end
    n_bytes_total = byte_q.size();

    // Synchronous reset.
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_bytes_sent == n_bytes_total);
    @(posedge clk);
    wait (chars_owed == 0);
    repeat (40) @(posedge clk);
    if (char_q.size() != 0) begin
      report_mismatch("characters never sent", char_q.size(), 0);
    end
    if (n_fail == 0) begin
      $display("[base64_stream_encoder_core] OK");
    end else begin
      $display("[base64_stream_encoder_core] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("[base64_stream_encoder_core] ERROR");
    $finish;
  end

endmodule
